/* sv/esc_pkg.sv */
// Shared types and constants for the environmental sensor compensation block.
`timescale 1ns / 1ps
package esc_pkg;

    localparam int RawW   = 20;
    localparam int ValueW = 33;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [1:0] FUNC_TEMP  = 2'd0;
    localparam logic [1:0] FUNC_PRESS = 2'd1;
    localparam logic [1:0] FUNC_HUM   = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [CfgIdxW-1:0] REG_TEMP_CAL    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_A = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_B = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_C = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUM_CAL_A   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_HUM_CAL_B   = 3'd5;

    // Last microstep of each formula, then the pressure steps around the divider.
    localparam logic [3:0] TEMP_LAST  = 4'd2;
    localparam logic [3:0] PRESS_LAST = 4'd9;
    localparam logic [3:0] HUM_LAST   = 4'd7;
    localparam logic [3:0] PRESS_DIVISOR_STEP = 4'd5;
    localparam logic [3:0] PRESS_DIVIDE_STEP  = 4'd6;
    localparam logic [3:0] PRESS_AFTER_DIV    = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_WAIT,
        ST_OUT
    } esc_state_t;

endpackage

/* sv/esc_sample_if.sv */
// Input channel carrying one raw reading and its formula selector.
`timescale 1ns / 1ps
interface esc_sample_if import esc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [1:0]      func;
    logic [RawW-1:0] raw;
    modport source(output valid, func, raw, input ready);
    modport sink(input valid, func, raw, output ready);
endinterface

/* sv/esc_result_if.sv */
// Output channel carrying one compensated value.
`timescale 1ns / 1ps
interface esc_result_if import esc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] value;
    logic              divisor_zero;
    modport source(output valid, value, divisor_zero, input ready);
    modport sink(input valid, value, divisor_zero, output ready);
endinterface

/* sv/esc_cfg_if.sv */
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface esc_cfg_if import esc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* sv/esc_mul.sv */
// Multi-cycle 64 x 64 multiplier (low 64 bits) built on one 32 x 32 multiplier.
`timescale 1ns / 1ps
module esc_mul import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] prod
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] pp_next;

    // Partial products: lo*lo, then lo*hi and hi*lo which only reach the upper word.
    always_comb
    begin
        mul_x = (cnt_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        mul_y = (cnt_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
        pp_next = {32'b0, mul_x} * {32'b0, mul_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 2'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            pp_reg <= pp_next;
            if (cnt_reg == 2'd1)
                acc_reg <= pp_reg;
            else if (cnt_reg != 2'd0)
                acc_reg[63:32] <= acc_reg[63:32] + pp_reg[31:0];
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* sv/esc_div.sv */
// Restoring unsigned 64 / 64 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module esc_div import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[63]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 6'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= 64'd0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* sv/env_sensor_compensation_unit.sv */
// Top level of the environmental sensor compensation block.
// Usage: write calibration registers over cfg (always ready) while the block is
// idle; index 0 temp_cal, 1..3 pressure coefficients, 4..5 humidity coefficients.
// A sample transaction carries func (0 temperature, 1 pressure, 2 humidity) and
// raw; each produces exactly one result transaction with value and divisor_zero.
// A temperature sample also updates the stored fine temperature that later
// pressure and humidity samples use.
// All products go through one 64-bit multiplier built from three 32 x 32 partial
// products. Pressure takes ten products and a pass through the bit-serial divider,
// and stops before the divider when the pressure divisor is zero. Func 3 returns
// zero without using the multiplier.
// The block takes one sample at a time; sample.ready is high only when idle, and it
// rises as the result is handed to the output register.
// The result sits in an output register, so a new sample may be accepted while
// a result still waits; a finished result waits there until the receiver takes it.
// Reset clears calibration registers and the fine temperature to zero and
// leaves the block idle with no result pending.
`timescale 1ns / 1ps
module env_sensor_compensation_unit import esc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    esc_cfg_if.sink      cfg,
    esc_sample_if.sink   sample,
    esc_result_if.source result
);

    esc_state_t state_reg, state_next;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_cal_a_reg;
    logic [63:0] press_cal_b_reg;
    logic [15:0] press_cal_c_reg;
    logic [47:0] hum_cal_a_reg;
    logic [31:0] hum_cal_b_reg;
    logic [31:0] fine_temp_reg;

    logic [1:0]        func_reg;
    logic [RawW-1:0]   raw_reg;
    logic [3:0]        step_reg;
    logic [63:0]       sq_reg;
    logic [63:0]       v1_reg;
    logic [63:0]       v2_reg;
    logic [63:0]       p_reg;
    logic              qneg_reg;
    logic [ValueW-1:0] res_value_reg;
    logic              res_flag_reg;
    logic [ValueW-1:0] out_value_reg;
    logic              out_flag_reg;
    logic              out_valid_reg;

    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] mul_prod;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic [63:0] div_quo;

    logic        last_step;
    logic        divisor_is_zero;
    logic        sample_accept;
    logic        out_free;

    // Calibration fields
    logic [15:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    // Working values
    logic [31:0] temp_a;
    logic [31:0] temp_b;
    logic [63:0] press_x;
    logic [63:0] press_n;
    logic [63:0] press_p13;
    logic [31:0] hum_x;
    logic [31:0] hum_y;

    // Write-back values
    logic [31:0] ft_new;
    logic [31:0] temp_scaled;
    logic [31:0] temp_out;
    logic [63:0] press_v2_new;
    logic [63:0] press_sum;
    logic [63:0] press_fin;
    logic [31:0] hum_t1;
    logic [31:0] hum_sub;
    logic [31:0] hum_xf;
    logic [31:0] hum_clamped;

    esc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    esc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg.ready     = 1'b1;
    assign sample.ready  = (state_reg == ST_IDLE);
    assign sample_accept = sample.valid && sample.ready;
    assign out_free      = !out_valid_reg || result.ready;

    assign result.valid        = out_valid_reg;
    assign result.value        = out_value_reg;
    assign result.divisor_zero = out_flag_reg;

    always_comb
    begin
        t1 = temp_cal_reg[47:32];
        t2 = {{16{temp_cal_reg[31]}}, temp_cal_reg[31:16]};
        t3 = {{16{temp_cal_reg[15]}}, temp_cal_reg[15:0]};
        p1 = {48'b0, press_cal_a_reg[63:48]};
        p2 = {{48{press_cal_a_reg[47]}}, press_cal_a_reg[47:32]};
        p3 = {{48{press_cal_a_reg[31]}}, press_cal_a_reg[31:16]};
        p4 = {{48{press_cal_a_reg[15]}}, press_cal_a_reg[15:0]};
        p5 = {{48{press_cal_b_reg[63]}}, press_cal_b_reg[63:48]};
        p6 = {{48{press_cal_b_reg[47]}}, press_cal_b_reg[47:32]};
        p7 = {{48{press_cal_b_reg[31]}}, press_cal_b_reg[31:16]};
        p8 = {{48{press_cal_b_reg[15]}}, press_cal_b_reg[15:0]};
        p9 = {{48{press_cal_c_reg[15]}}, press_cal_c_reg};
        h1 = {24'b0, hum_cal_a_reg[47:40]};
        h2 = {{16{hum_cal_a_reg[39]}}, hum_cal_a_reg[39:24]};
        h3 = {16'b0, hum_cal_a_reg[23:8]};
        h6 = {{24{hum_cal_a_reg[7]}}, hum_cal_a_reg[7:0]};
        h4 = {{16{hum_cal_b_reg[31]}}, hum_cal_b_reg[31:16]};
        h5 = {{16{hum_cal_b_reg[15]}}, hum_cal_b_reg[15:0]};
    end

    always_comb
    begin
        temp_a    = {15'b0, raw_reg[19:3]} - {15'b0, t1, 1'b0};
        temp_b    = {16'b0, raw_reg[19:4]} - {16'b0, t1};
        press_x   = {{32{fine_temp_reg[31]}}, fine_temp_reg} - 64'd128000;
        press_n   = ((64'd1048576 - {44'b0, raw_reg}) << 31) - v2_reg;
        press_p13 = 64'($signed(p_reg) >>> 13);
        hum_x     = fine_temp_reg - 32'd76800;
        hum_y     = 32'($signed(p_reg[31:0]) >>> 15);
    end

    // Operands of the current product, chosen by formula and step.
    always_comb
    begin
        mul_a = 64'd0;
        mul_b = 64'd0;
        case (func_reg)
            FUNC_TEMP:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = {32'b0, temp_a};      mul_b = {32'b0, t2}; end
                    4'd1:    begin mul_a = {32'b0, temp_b};      mul_b = {32'b0, temp_b}; end
                    default: begin mul_a = {32'b0, v2_reg[31:0]}; mul_b = {32'b0, t3}; end
                endcase
            end
            FUNC_PRESS:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = press_x; mul_b = press_x; end
                    4'd1:    begin mul_a = sq_reg;  mul_b = p6; end
                    4'd2:    begin mul_a = press_x; mul_b = p5; end
                    4'd3:    begin mul_a = sq_reg;  mul_b = p3; end
                    4'd4:    begin mul_a = press_x; mul_b = p2; end
                    4'd5:    begin mul_a = (64'd1 << 47) + v1_reg; mul_b = p1; end
                    4'd6:    begin mul_a = press_n; mul_b = 64'd3125; end
                    4'd7:    begin mul_a = p9;      mul_b = press_p13; end
                    4'd8:    begin mul_a = sq_reg;  mul_b = press_p13; end
                    default: begin mul_a = p8;      mul_b = p_reg; end
                endcase
            end
            default:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = {32'b0, h5};           mul_b = {32'b0, hum_x}; end
                    4'd1:    begin mul_a = {32'b0, hum_x};        mul_b = {32'b0, h6}; end
                    4'd2:    begin mul_a = {32'b0, hum_x};        mul_b = {32'b0, h3}; end
                    4'd3:    begin mul_a = {32'b0, v2_reg[31:0]}; mul_b = {32'b0, sq_reg[31:0]}; end
                    4'd4:    begin mul_a = {32'b0, p_reg[31:0]};  mul_b = {32'b0, h2}; end
                    4'd5:    begin mul_a = {32'b0, v1_reg[31:0]}; mul_b = {32'b0, v2_reg[31:0]}; end
                    4'd6:    begin mul_a = {32'b0, hum_y};        mul_b = {32'b0, hum_y}; end
                    default: begin mul_a = {32'b0, v2_reg[31:0]}; mul_b = {32'b0, h1}; end
                endcase
            end
        endcase
    end

    // Write-back arithmetic on the finished product, divider operands and last-step test.
    always_comb
    begin
        ft_new       = v1_reg[31:0] + 32'($signed(mul_prod[31:0]) >>> 14);
        temp_scaled  = (ft_new << 2) + ft_new + 32'd128;
        temp_out     = 32'($signed(temp_scaled) >>> 8);
        press_v2_new = 64'($signed(mul_prod) >>> 19);
        press_sum    = p_reg + v1_reg + press_v2_new;
        press_fin    = 64'($signed(press_sum) >>> 8) + (p7 << 4);
        hum_t1       = 32'($signed({2'b0, raw_reg[15:0], 14'b0} - {h4[11:0], 20'b0}
                                   - mul_prod[31:0] + 32'd16384) >>> 15);
        hum_sub      = 32'($signed(mul_prod[31:0]) >>> 4);
        hum_xf       = p_reg[31:0] - hum_sub;
        if (hum_xf[31])
            hum_clamped = 32'd0;
        else if (hum_xf > 32'd419430400)
            hum_clamped = 32'd419430400;
        else
            hum_clamped = hum_xf;
        divisor_is_zero = (64'($signed(mul_prod) >>> 33) == 64'd0);
        div_num = mul_prod[63] ? (64'd0 - mul_prod) : mul_prod;
        div_den = v1_reg[63] ? (64'd0 - v1_reg) : v1_reg;
        case (func_reg)
            FUNC_TEMP:  last_step = (step_reg == TEMP_LAST);
            FUNC_PRESS: last_step = (step_reg == PRESS_LAST);
            default:    last_step = (step_reg == HUM_LAST);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_accept)
                    state_next = (sample.func == FUNC_NONE) ? ST_OUT : ST_MUL_GO;
            end
            ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    if (last_step)
                        state_next = ST_OUT;
                    else if (func_reg == FUNC_PRESS && step_reg == PRESS_DIVISOR_STEP
                             && divisor_is_zero)
                        state_next = ST_OUT;
                    else if (func_reg == FUNC_PRESS && step_reg == PRESS_DIVIDE_STEP)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_WAIT;
                    end
                    else
                        state_next = ST_MUL_GO;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ST_MUL_GO;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Calibration registers and stored fine temperature.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg    <= '0;
            press_cal_a_reg <= '0;
            press_cal_b_reg <= '0;
            press_cal_c_reg <= '0;
            hum_cal_a_reg   <= '0;
            hum_cal_b_reg   <= '0;
            fine_temp_reg   <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_TEMP_CAL:    temp_cal_reg    <= cfg.data[47:0];
                    REG_PRESS_CAL_A: press_cal_a_reg <= cfg.data;
                    REG_PRESS_CAL_B: press_cal_b_reg <= cfg.data;
                    REG_PRESS_CAL_C: press_cal_c_reg <= cfg.data[15:0];
                    REG_HUM_CAL_A:   hum_cal_a_reg   <= cfg.data[47:0];
                    REG_HUM_CAL_B:   hum_cal_b_reg   <= cfg.data[31:0];
                    default:         ;
                endcase
            end
            if (state_reg == ST_MUL_WAIT && mul_done && func_reg == FUNC_TEMP && last_step)
                fine_temp_reg <= ft_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_value_reg <= res_value_reg;
            out_flag_reg  <= res_flag_reg;
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sample_accept)
        begin
            func_reg      <= sample.func;
            raw_reg       <= sample.raw;
            step_reg      <= 4'd0;
            res_value_reg <= '0;
            res_flag_reg  <= 1'b0;
        end
        else if (state_reg == ST_DIV_WAIT && div_done)
        begin
            p_reg    <= qneg_reg ? (64'd0 - div_quo) : div_quo;
            step_reg <= PRESS_AFTER_DIV;
        end
        else if (state_reg == ST_MUL_WAIT && mul_done)
        begin
            step_reg <= step_reg + 4'd1;
            case (func_reg)
                FUNC_TEMP:
                begin
                    case (step_reg)
                        4'd0:    v1_reg <= {32'b0, 32'($signed(mul_prod[31:0]) >>> 11)};
                        4'd1:    v2_reg <= {32'b0, 32'($signed(mul_prod[31:0]) >>> 12)};
                        default: res_value_reg <= {temp_out[31], temp_out};
                    endcase
                end
                FUNC_PRESS:
                begin
                    case (step_reg)
                        4'd0: sq_reg <= mul_prod;
                        4'd1: v2_reg <= mul_prod;
                        4'd2: v2_reg <= v2_reg + (mul_prod << 17) + (p4 << 35);
                        4'd3: v1_reg <= 64'($signed(mul_prod) >>> 8);
                        4'd4: v1_reg <= v1_reg + (mul_prod << 12);
                        4'd5:
                        begin
                            v1_reg <= 64'($signed(mul_prod) >>> 33);
                            if (divisor_is_zero)
                            begin
                                res_value_reg <= '0;
                                res_flag_reg  <= 1'b1;
                            end
                        end
                        4'd6: qneg_reg <= mul_prod[63] ^ v1_reg[63];
                        4'd7: sq_reg <= mul_prod;
                        4'd8: v1_reg <= 64'($signed(mul_prod) >>> 25);
                        default: res_value_reg <= {1'b0, press_fin[31:0]};
                    endcase
                end
                default:
                begin
                    case (step_reg)
                        4'd0: v1_reg <= {32'b0, hum_t1};
                        4'd1: v2_reg <= {32'b0, 32'($signed(mul_prod[31:0]) >>> 10)};
                        4'd2: sq_reg <= {32'b0, 32'($signed(mul_prod[31:0]) >>> 11)
                                                + 32'd32768};
                        4'd3: p_reg <= {32'b0, 32'($signed(mul_prod[31:0]) >>> 10)
                                               + 32'd2097152};
                        4'd4: v2_reg <= {32'b0, 32'($signed(mul_prod[31:0] + 32'd8192) >>> 14)};
                        4'd5: p_reg <= {32'b0, mul_prod[31:0]};
                        4'd6: v2_reg <= {32'b0, 32'($signed(mul_prod[31:0]) >>> 7)};
                        default: res_value_reg <= {13'b0, hum_clamped[31:12]};
                    endcase
                end
            endcase
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the environmental sensor compensation unit.
`timescale 1ns / 1ps
module testbench import esc_pkg::*;
();

    localparam int  LIMIT       = 3000000;
    localparam int  DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [1:0]      func;
        logic [RawW-1:0] raw;
    } sample_t;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              divisor_zero;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle = 0;
    int   errors = 0;
    int   results_seen = 0;
    int   hold_cycles = 0;
    bit   hold_done = 1'b0;

    logic [CfgDataW-1:0] cal_regs [0:5];
    logic signed [31:0]  fine_temp;

    sample_t  sample_q[$];
    reading_t reading_q[$];

    esc_cfg_if    cfg_ch();
    esc_sample_if sample_ch();
    esc_result_if result_ch();

    env_sensor_compensation_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch),
        .sample(sample_ch),
        .result(result_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Both sides run without gaps during one window early in the run.
    function automatic bit idle_roll();
        if (cycle > 20000 && cycle < 40000)
            return 1'b0;
        return $urandom_range(99) < 29;
    endfunction

    function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = n[63] ? 64'd0 - n : n;
        md = d[63] ? 64'd0 - d : d;
        q  = mn / md;
        return (n[63] != d[63]) ? 64'd0 - q : q;
    endfunction

    function automatic reading_t compensate(sample_t s);
        reading_t r;
        logic signed [31:0] t1, t2, t3, a, b, m, v1w, v2w, outw;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, adc, x, m1, m2, inn, q, ht1, ht2;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, pm, pn, p, sh;
        r = '0;
        case (s.func)
            FUNC_TEMP:
            begin
                t1 = {16'd0, cal_regs[REG_TEMP_CAL][47:32]};
                t2 = {{16{cal_regs[REG_TEMP_CAL][31]}}, cal_regs[REG_TEMP_CAL][31:16]};
                t3 = {{16{cal_regs[REG_TEMP_CAL][15]}}, cal_regs[REG_TEMP_CAL][15:0]};
                a = {15'd0, s.raw[19:3]};
                a = a - (t1 <<< 1);
                m = a * t2;
                v1w = m >>> 11;
                b = {16'd0, s.raw[19:4]};
                b = b - t1;
                m = b * b;
                m = m >>> 12;
                m = m * t3;
                v2w = m >>> 14;
                fine_temp = v1w + v2w;
                m = fine_temp * 32'sd5 + 32'sd128;
                outw = m >>> 8;
                r.value = {outw[31], outw};
            end
            FUNC_PRESS:
            begin
                p1 = {48'd0, cal_regs[REG_PRESS_CAL_A][63:48]};
                p2 = {{48{cal_regs[REG_PRESS_CAL_A][47]}}, cal_regs[REG_PRESS_CAL_A][47:32]};
                p3 = {{48{cal_regs[REG_PRESS_CAL_A][31]}}, cal_regs[REG_PRESS_CAL_A][31:16]};
                p4 = {{48{cal_regs[REG_PRESS_CAL_A][15]}}, cal_regs[REG_PRESS_CAL_A][15:0]};
                p5 = {{48{cal_regs[REG_PRESS_CAL_B][63]}}, cal_regs[REG_PRESS_CAL_B][63:48]};
                p6 = {{48{cal_regs[REG_PRESS_CAL_B][47]}}, cal_regs[REG_PRESS_CAL_B][47:32]};
                p7 = {{48{cal_regs[REG_PRESS_CAL_B][31]}}, cal_regs[REG_PRESS_CAL_B][31:16]};
                p8 = {{48{cal_regs[REG_PRESS_CAL_B][15]}}, cal_regs[REG_PRESS_CAL_B][15:0]};
                p9 = {{48{cal_regs[REG_PRESS_CAL_C][15]}}, cal_regs[REG_PRESS_CAL_C][15:0]};
                v1 = {{32{fine_temp[31]}}, fine_temp};
                v1 = v1 - 64'sd128000;
                v2 = v1 * v1 * p6;
                v2 = v2 + ((v1 * p5) <<< 17);
                v2 = v2 + (p4 <<< 35);
                pm = v1 * v1 * p3;
                pn = v1 * p2;
                v1 = (pm >>> 8) + (pn <<< 12);
                pm = (64'sd1 <<< 47) + v1;
                pm = pm * p1;
                v1 = pm >>> 33;
                if (v1 == 64'sd0)
                begin
                    r.divisor_zero = 1'b1;
                end
                else
                begin
                    p = 64'sd1048576 - $signed({44'd0, s.raw});
                    pm = ((p <<< 31) - v2) * 64'sd3125;
                    p = div_trunc(pm, v1);
                    sh = p >>> 13;
                    pm = p9 * sh * sh;
                    v1 = pm >>> 25;
                    pm = p8 * p;
                    v2 = pm >>> 19;
                    pm = p + v1 + v2;
                    p = (pm >>> 8) + (p7 <<< 4);
                    r.value = {1'b0, p[31:0]};
                end
            end
            FUNC_HUM:
            begin
                h1 = {24'd0, cal_regs[REG_HUM_CAL_A][47:40]};
                h2 = {{16{cal_regs[REG_HUM_CAL_A][39]}}, cal_regs[REG_HUM_CAL_A][39:24]};
                h3 = {16'd0, cal_regs[REG_HUM_CAL_A][23:8]};
                h6 = {{24{cal_regs[REG_HUM_CAL_A][7]}}, cal_regs[REG_HUM_CAL_A][7:0]};
                h4 = {{16{cal_regs[REG_HUM_CAL_B][31]}}, cal_regs[REG_HUM_CAL_B][31:16]};
                h5 = {{16{cal_regs[REG_HUM_CAL_B][15]}}, cal_regs[REG_HUM_CAL_B][15:0]};
                adc = {16'd0, s.raw[15:0]};
                x = fine_temp - 32'sd76800;
                m1 = h5 * x;
                ht1 = (adc <<< 14) - (h4 <<< 20) - m1 + 32'sd16384;
                ht1 = ht1 >>> 15;
                m1 = x * h6;
                m2 = x * h3;
                inn = (m1 >>> 10) * ((m2 >>> 11) + 32'sd32768);
                inn = (inn >>> 10) + 32'sd2097152;
                m1 = inn * h2 + 32'sd8192;
                ht2 = m1 >>> 14;
                x = ht1 * ht2;
                q = x >>> 15;
                m1 = q * q;
                m1 = m1 >>> 7;
                m1 = m1 * h1;
                x = x - (m1 >>> 4);
                if (x < 0)
                    x = 0;
                if (x > 32'sd419430400)
                    x = 32'sd419430400;
                r.value = {13'd0, x[31:12]};
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sample driver; the prediction is made when the transaction is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.func  <= '0;
            sample_ch.raw   <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                reading_q.push_back(compensate('{sample_ch.func, sample_ch.raw}));
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (sample_q.size() > 0 && !idle_roll())
                begin
                    sample_t s;
                    s = sample_q.pop_front();
                    sample_ch.valid <= 1'b1;
                    sample_ch.func  <= s.func;
                    sample_ch.raw   <= s.raw;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the receiver, started once enough results went by.
    always @(posedge clk)
    begin
        if (!hold_done && results_seen >= 400)
        begin
            hold_done   <= 1'b1;
            hold_cycles <= 600;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (reading_q.size() == 0)
                begin
                    $error("unexpected result transaction value=%h", result_ch.value);
                    errors = errors + 1;
                end
                else
                begin
                    reading_t e;
                    e = reading_q.pop_front();
                    if (result_ch.value !== e.value)
                    begin
                        $error("value: expected %h actual %h", e.value, result_ch.value);
                        errors = errors + 1;
                    end
                    if (result_ch.divisor_zero !== e.divisor_zero)
                    begin
                        $error("divisor_zero: expected %b actual %b",
                               e.divisor_zero, result_ch.divisor_zero);
                        errors = errors + 1;
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (hold_cycles > 0)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= !idle_roll();
        end
    end

    task automatic wait_drained();
        while (sample_q.size() > 0 || sample_ch.valid || reading_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (index)
            REG_TEMP_CAL:    cal_regs[REG_TEMP_CAL]    = {16'd0, data[47:0]};
            REG_PRESS_CAL_C: cal_regs[REG_PRESS_CAL_C] = {48'd0, data[15:0]};
            REG_HUM_CAL_A:   cal_regs[REG_HUM_CAL_A]   = {16'd0, data[47:0]};
            REG_HUM_CAL_B:   cal_regs[REG_HUM_CAL_B]   = {32'd0, data[31:0]};
            default:         cal_regs[index] = data;
        endcase
    endtask

    task automatic write_all(logic [CfgDataW-1:0] v [0:5]);
        cfg_write(REG_TEMP_CAL, v[0]);
        cfg_write(REG_PRESS_CAL_A, v[1]);
        cfg_write(REG_PRESS_CAL_B, v[2]);
        cfg_write(REG_PRESS_CAL_C, v[3]);
        cfg_write(REG_HUM_CAL_A, v[4]);
        cfg_write(REG_HUM_CAL_B, v[5]);
    endtask

    task automatic add_sample(logic [1:0] func, logic [RawW-1:0] raw);
        sample_q.push_back('{func, raw});
    endtask

    // Mostly a temperature reading followed by pressure and humidity, as in use.
    task automatic add_random(int count);
        int n;
        int k;
        n = 0;
        while (n < count)
        begin
            k = $urandom_range(99);
            if (k < 70)
            begin
                add_sample(FUNC_TEMP, $urandom_range(20'hFFFFF));
                add_sample(FUNC_PRESS, $urandom_range(20'hFFFFF));
                add_sample(FUNC_HUM, $urandom_range(20'hFFFFF));
                n = n + 3;
            end
            else
            begin
                add_sample((k < 95) ? 2'($urandom_range(2)) : FUNC_NONE,
                           $urandom_range(20'hFFFFF));
                n = n + 1;
            end
        end
    endtask

    initial
    begin
        logic [CfgDataW-1:0] typical [0:5];
        logic [CfgDataW-1:0] cal [0:5];
        for (int i = 0; i < 6; i++)
            cal_regs[i] = '0;
        fine_temp = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: pressure divisor is zero, unused selector returns zero.
        add_sample(FUNC_PRESS, 20'h00000);
        add_sample(FUNC_HUM, 20'hFFFFF);
        add_sample(FUNC_TEMP, 20'hFFFFF);
        add_sample(FUNC_NONE, 20'hFFFFF);
        wait_drained();

        typical[0] = {16'd27504, 16'd26435, -16'sd1000};
        typical[1] = {16'd36477, -16'sd10685, 16'd3024, 16'd2855};
        typical[2] = {16'd140, -16'sd7, 16'd15500, -16'sd14600};
        typical[3] = 64'd6000;
        typical[4] = {8'd75, 16'd362, 16'd0, 8'd30};
        typical[5] = {16'd313, 16'd50};
        write_all(typical);

        // Pressure before any temperature step uses the stored fine temperature.
        add_sample(FUNC_PRESS, 20'h65000);
        add_sample(FUNC_HUM, 20'h06E00);
        add_sample(FUNC_TEMP, 20'h7E000);
        add_sample(FUNC_PRESS, 20'h00000);
        add_sample(FUNC_PRESS, 20'hFFFFF);
        add_sample(FUNC_HUM, 20'h00000);
        add_sample(FUNC_HUM, 20'h0FFFF);
        add_sample(FUNC_TEMP, 20'h00000);
        add_sample(FUNC_PRESS, 20'h80000);
        add_sample(FUNC_HUM, 20'h08000);
        add_sample(FUNC_TEMP, 20'hFFFFF);
        add_sample(FUNC_HUM, 20'hF0000);
        add_sample(FUNC_NONE, 20'h00000);
        add_random(250);
        wait_drained();

        // Every coefficient at its bit extremes, then typical values with random low bits, then random calibrations.
        for (int phase = 0; phase < 7; phase++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                case (phase)
                    0:       cal[i] = '1;
                    1:       cal[i] = 64'h8000_8000_8000_8000;
                    2:       cal[i] = 64'h7FFF_7FFF_7FFF_7FFF;
                    3:       cal[i] = typical[i] ^ ({$urandom, $urandom} & 64'h0003_0003_0003_0003);
                    default: cal[i] = {$urandom, $urandom};
                endcase
            end
            write_all(cal);
            add_random((phase == 3) ? 250 : 100);
            wait_drained();
        end

        write_all(typical);
        add_random(60);
        wait_drained();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* files.f */
sv/esc_pkg.sv
sv/esc_sample_if.sv
sv/esc_result_if.sv
sv/esc_cfg_if.sv
sv/esc_mul.sv
sv/esc_div.sv
sv/env_sensor_compensation_unit.sv
tb/sv/testbench.sv
